// ===== sv/spm_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and elaboration-time log2 helpers for the stereo peak meter
package spm_pkg;

   // default parameter values
   localparam int LOG_TABLE_ENTRIES_DEF = 32;
   localparam int PEAK_BITS_DEF         = 31;
   localparam int QUEUE_DEPTH_DEF       = 4;

   // field and datapath widths
   localparam int NUM_CH      = 2;
   localparam int PEAK_W      = 31;
   localparam int EXP_W       = 5;
   localparam int FRAC_W      = 16;
   localparam int TAB_W       = 17;
   localparam int LOG_W       = 21;
   localparam int DIFF_W      = 22;
   localparam int SCALE_W     = 20;
   localparam int PROD_W      = 42;
   localparam int LEVEL_SHIFT = 24;
   localparam int PK_W        = 17;
   localparam int LEVEL_W     = 16;
   localparam int FALL_W      = 11;
   localparam int BAR_W       = 7;
   localparam int OVER_W      = 2;
   localparam int CSR_W       = 16;
   localparam int CSR_INDEX_W = 2;

   // register stages inside the log2 unit
   localparam int LOG_LAT = 5;

   // log2 table and scaling
   localparam logic [TAB_W-1:0]          TAB_ONE     = 17'h1_0000;
   localparam logic [PEAK_W-1:0]         FS_16       = 31'd32767;
   localparam logic [PEAK_W-1:0]         FS_32       = 31'h7FFF_FFFF;
   localparam logic signed [SCALE_W-1:0] DB_SCALE_Q8 = 20'sd394566;
   localparam logic signed [PROD_W-1:0]  ROUND_HALF  = 42'sh80_0000;

   // item codes
   localparam logic MODE_IDLE = 1'b1;

   // register reset values
   localparam logic                      FS_SEL_RESET = 1'b0;
   localparam logic [FALL_W-1:0]         FALL_RESET   = 11'd154;
   localparam logic signed [LEVEL_W-1:0] FLOOR_RESET  = -16'sd10240;

   // bar mapping over the 40 dB span
   localparam int                    V_W         = 23;
   localparam logic signed [V_W-1:0] BAR_SCALE   = 23'sd100;
   localparam logic signed [V_W-1:0] BAR_OFFSET  = 23'sd1029120;
   localparam logic signed [V_W-1:0] BAR_LOW     = 23'sd10240;
   localparam logic signed [V_W-1:0] BAR_HIGH    = 23'sd1024000;
   localparam int                    BAR_SHIFT   = 11;
   localparam int                    X_W         = 9;
   localparam int                    QP_W        = 17;
   localparam logic [QP_W-1:0]       RECIP_5     = 17'd205;
   localparam int                    RECIP_SHIFT = 10;
   localparam logic [BAR_W-1:0]      BAR_FULL    = 7'd100;
   localparam logic [BAR_W-1:0]      BAR_EMPTY   = 7'd0;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FULL_SCALE_SELECT = 2'd0,
      CSR_FALL_STEP         = 2'd1,
      CSR_FLOOR_LEVEL       = 2'd2
   } spm_csr_index_type;

   // configuration registers
   typedef struct packed {
      logic                      full_scale_select;
      logic [FALL_W-1:0]         fall_step;
      logic signed [LEVEL_W-1:0] floor_level;
   } spm_cfg_type;

   // input beat
   typedef struct packed {
      logic              mode;
      logic [PEAK_W-1:0] chan0_peak;
      logic [PEAK_W-1:0] chan1_peak;
   } spm_req_type;

   // result beat
   typedef struct packed {
      logic signed [LEVEL_W-1:0] chan0_level;
      logic signed [LEVEL_W-1:0] chan1_level;
      logic [BAR_W-1:0]          chan0_bar;
      logic [BAR_W-1:0]          chan1_bar;
      logic [OVER_W-1:0]         over_range;
   } spm_rsp_type;

   // peak levels handed from front end to back end
   typedef struct packed {
      logic [OVER_W-1:0]      over_range;
      logic signed [PK_W-1:0] chan0_pk;
      logic signed [PK_W-1:0] chan1_pk;
   } spm_pk_type;

   // table entry floor(65536*log2(1+i/n)) by repeated squaring, elaboration only
   function automatic logic [TAB_W-1:0] log_tab_entry(int unsigned n, int unsigned i);
      logic [63:0]      num;
      logic [63:0]      x;
      logic [63:0]      part;
      logic [TAB_W-1:0] acc;
      num  = 64'(n + i) << 30;
      x    = '0;
      part = '0;
      acc  = '0;
      if (i >= n) begin
         acc = TAB_ONE;
      end else begin
         // restoring long division for (n+i)/n in Q30
         for (int b = 63; b >= 0; b--) begin
            part = {part[62:0], num[b]};
            if (part >= 64'(n)) begin
               part = part - 64'(n);
               x[b] = 1'b1;
            end
         end
         // one result bit per squaring
         for (int b = FRAC_W - 1; b >= 0; b--) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
               x      = x >> 1;
               acc[b] = 1'b1;
            end
         end
      end
      return acc;
   endfunction

   // log2 in Q16 of a constant, matching the runtime datapath
   function automatic logic [LOG_W-1:0] log2_const(int unsigned n, logic [PEAK_W-1:0] p);
      logic [EXP_W-1:0]  e;
      logic [PEAK_W-1:0] pn;
      logic [FRAC_W-1:0] f;
      logic [63:0]       mul;
      logic [63:0]       dlt;
      int unsigned       idx;
      logic [TAB_W-1:0]  lo;
      logic [TAB_W-1:0]  hi;
      e = '0;
      for (int i = 0; i < PEAK_W; i++) begin
         if (p[i]) begin
            e = EXP_W'(i);
         end
      end
      pn  = p << (EXP_W'(PEAK_W - 1) - e);
      f   = pn[PEAK_W-2 -: FRAC_W];
      mul = 64'(f) * 64'(n);
      idx = 32'(mul >> FRAC_W);
      lo  = log_tab_entry(n, idx);
      hi  = log_tab_entry(n, idx + 1);
      dlt = (64'(hi - lo) * 64'(mul[FRAC_W-1:0])) >> FRAC_W;
      return LOG_W'({e, {FRAC_W{1'b0}}}) + LOG_W'(lo) + LOG_W'(dlt);
   endfunction

endpackage

// ===== sv/spm_log2.sv =====
`timescale 1ns / 1ps
// pipelined log2 in Q16: leading-one detect, normalise, interpolated table lookup
module spm_log2 #(
   parameter int LOG_TABLE_ENTRIES = spm_pkg::LOG_TABLE_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [spm_pkg::PEAK_W-1:0]     peak,
   output logic [spm_pkg::LOG_W-1:0]      log_q16
);

   localparam int IDX_W = $clog2(LOG_TABLE_ENTRIES + 1);
   localparam int MUL_W = spm_pkg::FRAC_W + IDX_W;
   localparam int MP_W  = spm_pkg::TAB_W + spm_pkg::FRAC_W;

   // interpolation table, fixed at elaboration
   logic [spm_pkg::TAB_W-1:0] tab_w [LOG_TABLE_ENTRIES+1];

   for (genvar gi = 0; gi <= LOG_TABLE_ENTRIES; gi++) begin : g_tab
      localparam logic [spm_pkg::TAB_W-1:0] ENTRY =
         spm_pkg::log_tab_entry(LOG_TABLE_ENTRIES, gi);
      assign tab_w[gi] = ENTRY;
   end

   logic [spm_pkg::EXP_W-1:0]  e_a_in, e_a_ff, e_b_ff, e_c_ff, e_d_ff;
   logic [spm_pkg::PEAK_W-1:0] p_a_ff;
   logic [spm_pkg::PEAK_W-1:0] pn_w;
   logic [spm_pkg::FRAC_W-1:0] f_w;
   logic [MUL_W-1:0]           mul_w;
   logic [IDX_W-1:0]           idx_b_in, idx_b_ff, idx_nx_w;
   logic [spm_pkg::FRAC_W-1:0] rem_b_in, rem_b_ff, rem_c_ff;
   logic [spm_pkg::TAB_W-1:0]  lo_c_in, lo_c_ff, lo_d_ff;
   logic [spm_pkg::TAB_W-1:0]  dif_c_in, dif_c_ff;
   logic [MP_W-1:0]            mp_w;
   logic [spm_pkg::TAB_W-1:0]  mh_d_in, mh_d_ff;
   logic [spm_pkg::LOG_W-1:0]  l_in, l_ff;

   // leading-one position
   always_comb begin
      e_a_in = '0;
      for (int i = 0; i < spm_pkg::PEAK_W; i++) begin
         if (peak[i]) begin
            e_a_in = spm_pkg::EXP_W'(i);
         end
      end
   end

   // normalise and split the fraction into table index and remainder
   always_comb begin
      pn_w     = p_a_ff << (spm_pkg::EXP_W'(spm_pkg::PEAK_W - 1) - e_a_ff);
      f_w      = pn_w[spm_pkg::PEAK_W-2 -: spm_pkg::FRAC_W];
      mul_w    = MUL_W'(f_w) * MUL_W'(LOG_TABLE_ENTRIES);
      idx_b_in = mul_w[MUL_W-1 -: IDX_W];
      rem_b_in = mul_w[spm_pkg::FRAC_W-1:0];
   end

   // table lookup of both neighbours
   always_comb begin
      idx_nx_w = idx_b_ff + IDX_W'(1);
      lo_c_in  = tab_w[idx_b_ff];
      dif_c_in = tab_w[idx_nx_w] - tab_w[idx_b_ff];
   end

   // linear interpolation
   always_comb begin
      mp_w    = MP_W'(dif_c_ff) * MP_W'(rem_c_ff);
      mh_d_in = mp_w[MP_W-1:spm_pkg::FRAC_W];
   end

   // integer part plus fraction
   always_comb begin
      l_in = spm_pkg::LOG_W'({e_d_ff, {spm_pkg::FRAC_W{1'b0}}}) +
             spm_pkg::LOG_W'(lo_d_ff) + spm_pkg::LOG_W'(mh_d_ff);
   end

   // stage registers, held while the pipe is stalled
   always_ff @(posedge clock) begin
      if (enable) begin
         e_a_ff   <= e_a_in;
         p_a_ff   <= peak;
         e_b_ff   <= e_a_ff;
         idx_b_ff <= idx_b_in;
         rem_b_ff <= rem_b_in;
         e_c_ff   <= e_b_ff;
         lo_c_ff  <= lo_c_in;
         dif_c_ff <= dif_c_in;
         rem_c_ff <= rem_b_ff;
         e_d_ff   <= e_c_ff;
         lo_d_ff  <= lo_c_ff;
         mh_d_ff  <= mh_d_in;
         l_ff     <= l_in;
      end
   end

   assign log_q16 = l_ff;

endmodule

// ===== sv/spm_front.sv =====
`timescale 1ns / 1ps
// front end: takes input beats, classifies peaks and forms the peak level in 1/256 dB
module spm_front #(
   parameter int LOG_TABLE_ENTRIES = spm_pkg::LOG_TABLE_ENTRIES_DEF,
   parameter int PEAK_BITS         = spm_pkg::PEAK_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spm_pkg::spm_cfg_type cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  spm_pkg::spm_req_type req_data,
   input  logic                 q_full,
   output logic                 q_push,
   output spm_pkg::spm_pk_type  q_data
);

   localparam int FRONT_LAT = spm_pkg::LOG_LAT + 3;
   localparam int LVL_W     = spm_pkg::PROD_W - spm_pkg::LEVEL_SHIFT;

   localparam logic [spm_pkg::PEAK_W-1:0] PEAK_MASK =
      (PEAK_BITS >= spm_pkg::PEAK_W) ? {spm_pkg::PEAK_W{1'b1}} :
      spm_pkg::PEAK_W'((64'd1 << PEAK_BITS) - 64'd1);
   localparam logic [spm_pkg::LOG_W-1:0] LOG_FS_16 =
      spm_pkg::log2_const(LOG_TABLE_ENTRIES, spm_pkg::FS_16);
   localparam logic [spm_pkg::LOG_W-1:0] LOG_FS_32 =
      spm_pkg::log2_const(LOG_TABLE_ENTRIES, spm_pkg::FS_32);

   logic                                  adv_w;
   logic [FRONT_LAT-1:0]                  vld_in, vld_ff;
   logic [FRONT_LAT-2:0][spm_pkg::NUM_CH-1:0] zero_in, zero_ff, over_in, over_ff;
   logic [spm_pkg::NUM_CH-1:0]            zero_s1_w, over_s1_w;
   logic [spm_pkg::PEAK_W-1:0]            fs_w;
   logic [spm_pkg::LOG_W-1:0]             log_fs_w;
   logic [spm_pkg::PEAK_W-1:0]            p_in [spm_pkg::NUM_CH];
   logic [spm_pkg::PEAK_W-1:0]            p_ff [spm_pkg::NUM_CH];
   logic [spm_pkg::LOG_W-1:0]             l_w  [spm_pkg::NUM_CH];
   logic signed [spm_pkg::DIFF_W-1:0]     d_in [spm_pkg::NUM_CH];
   logic signed [spm_pkg::DIFF_W-1:0]     d_ff [spm_pkg::NUM_CH];
   logic signed [spm_pkg::PROD_W-1:0]     prod_in [spm_pkg::NUM_CH];
   logic signed [spm_pkg::PROD_W-1:0]     prod_ff [spm_pkg::NUM_CH];
   logic signed [LVL_W-1:0]               lvl_w [spm_pkg::NUM_CH];
   logic signed [spm_pkg::PK_W-1:0]       pk_w  [spm_pkg::NUM_CH];

   // pipe moves unless a finished beat is blocked by a full queue
   assign adv_w     = !(vld_ff[FRONT_LAT-1] && q_full);
   assign req_stall = !adv_w;
   assign q_push    = vld_ff[FRONT_LAT-1] && adv_w;

   // full scale selection
   assign fs_w     = cfg.full_scale_select ? spm_pkg::FS_32 : spm_pkg::FS_16;
   assign log_fs_w = cfg.full_scale_select ? LOG_FS_32 : LOG_FS_16;

   // input capture: idle tick stands for peaks of one
   always_comb begin
      if (req_data.mode == spm_pkg::MODE_IDLE) begin
         p_in[0] = spm_pkg::PEAK_W'(1);
         p_in[1] = spm_pkg::PEAK_W'(1);
      end else begin
         p_in[0] = req_data.chan0_peak & PEAK_MASK;
         p_in[1] = req_data.chan1_peak & PEAK_MASK;
      end
   end

   // classify zero and over-range peaks
   always_comb begin
      for (int ch = 0; ch < spm_pkg::NUM_CH; ch++) begin
         zero_s1_w[ch] = (p_ff[ch] == '0);
         over_s1_w[ch] = (p_ff[ch] > fs_w);
      end
   end

   // valid and flag lines alongside the datapath
   assign vld_in  = {vld_ff[FRONT_LAT-2:0], req_valid};
   assign zero_in = {zero_ff[FRONT_LAT-3:0], zero_s1_w};
   assign over_in = {over_ff[FRONT_LAT-3:0], over_s1_w};

   // one log2 unit per channel
   for (genvar gc = 0; gc < spm_pkg::NUM_CH; gc++) begin : g_log
      spm_log2 #(
         .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
      ) u_log2 (
         .clock  (clock),
         .enable (adv_w),
         .peak   (p_ff[gc]),
         .log_q16(l_w[gc])
      );
   end

   // distance to full scale, then scale to 1/256 dB with rounding
   always_comb begin
      for (int ch = 0; ch < spm_pkg::NUM_CH; ch++) begin
         d_in[ch]    = $signed({1'b0, l_w[ch]}) - $signed({1'b0, log_fs_w});
         prod_in[ch] = spm_pkg::PROD_W'(d_ff[ch]) * spm_pkg::PROD_W'(spm_pkg::DB_SCALE_Q8) +
                       spm_pkg::ROUND_HALF;
      end
   end

   // peak level with zero, over-range and positive cases
   always_comb begin
      for (int ch = 0; ch < spm_pkg::NUM_CH; ch++) begin
         lvl_w[ch] = prod_ff[ch][spm_pkg::PROD_W-1:spm_pkg::LEVEL_SHIFT];
         if (zero_ff[FRONT_LAT-2][ch]) begin
            pk_w[ch] = spm_pkg::PK_W'(cfg.floor_level);
         end else if (over_ff[FRONT_LAT-2][ch] || (lvl_w[ch] > 0)) begin
            pk_w[ch] = '0;
         end else begin
            pk_w[ch] = lvl_w[ch][spm_pkg::PK_W-1:0];
         end
      end
   end

   always_comb begin
      q_data.over_range = over_ff[FRONT_LAT-2];
      q_data.chan0_pk   = pk_w[0];
      q_data.chan1_pk   = pk_w[1];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv_w) begin
         vld_ff <= vld_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv_w) begin
         zero_ff <= zero_in;
         over_ff <= over_in;
         for (int ch = 0; ch < spm_pkg::NUM_CH; ch++) begin
            p_ff[ch]    <= p_in[ch];
            d_ff[ch]    <= d_in[ch];
            prod_ff[ch] <= prod_in[ch];
         end
      end
   end

endmodule

// ===== sv/spm_queue.sv =====
`timescale 1ns / 1ps
// short queue of peak levels between front end and back end
module spm_queue #(
   parameter int DEPTH = spm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  spm_pkg::spm_pk_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output spm_pkg::spm_pk_type head_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   spm_pkg::spm_pk_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_in, wr_ptr_ff, rd_ptr_in, rd_ptr_ff;
   logic [CNT_W-1:0]    cnt_in, cnt_ff;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // slot write
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/spm_back.sv =====
`timescale 1ns / 1ps
// back end: held-level decay and clamp, bar mapping and the result register
module spm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  spm_pkg::spm_cfg_type cfg,
   input  logic                 q_valid,
   input  spm_pkg::spm_pk_type  q_data,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output spm_pkg::spm_rsp_type rsp_data
);

   localparam int HW = spm_pkg::LEVEL_W + 2;

   logic en_o_w, en_b_w, en_h_w;

   logic signed [spm_pkg::LEVEL_W-1:0] held_in [spm_pkg::NUM_CH];
   logic signed [spm_pkg::LEVEL_W-1:0] held_ff [spm_pkg::NUM_CH];
   logic signed [HW-1:0]               pk_w    [spm_pkg::NUM_CH];
   logic signed [HW-1:0]               dec_w   [spm_pkg::NUM_CH];
   logic signed [HW-1:0]               new_w   [spm_pkg::NUM_CH];
   logic signed [HW-1:0]               floor_w;

   logic                               h_vld_ff;
   logic signed [spm_pkg::LEVEL_W-1:0] h_lvl_ff [spm_pkg::NUM_CH];
   logic [spm_pkg::OVER_W-1:0]         h_over_ff;

   logic                               b_vld_ff;
   logic signed [spm_pkg::LEVEL_W-1:0] b_lvl_ff [spm_pkg::NUM_CH];
   logic [spm_pkg::OVER_W-1:0]         b_over_ff;
   logic signed [spm_pkg::V_W-1:0]     v_w      [spm_pkg::NUM_CH];
   logic [spm_pkg::NUM_CH-1:0]         b_zero_in, b_zero_ff, b_full_in, b_full_ff;
   logic [spm_pkg::X_W-1:0]            b_x_in   [spm_pkg::NUM_CH];
   logic [spm_pkg::X_W-1:0]            b_x_ff   [spm_pkg::NUM_CH];

   logic [spm_pkg::QP_W-1:0]           qp_w     [spm_pkg::NUM_CH];
   logic [spm_pkg::BAR_W-1:0]          bar_w    [spm_pkg::NUM_CH];
   logic                               rsp_valid_ff;
   spm_pkg::spm_rsp_type               rsp_data_in, rsp_data_ff;

   // stage enables, each stage moves when the next one frees up
   assign en_o_w = !rsp_valid_ff || !rsp_stall;
   assign en_b_w = !b_vld_ff || en_o_w;
   assign en_h_w = !h_vld_ff || en_b_w;
   assign q_pop  = q_valid && en_h_w;

   // held level: larger of peak and decayed level, floored, capped at 0 dB
   always_comb begin
      pk_w[0] = HW'(q_data.chan0_pk);
      pk_w[1] = HW'(q_data.chan1_pk);
      floor_w = HW'(cfg.floor_level);
      for (int ch = 0; ch < spm_pkg::NUM_CH; ch++) begin
         dec_w[ch] = HW'(held_ff[ch]) - $signed(HW'(cfg.fall_step));
         new_w[ch] = (pk_w[ch] > dec_w[ch]) ? pk_w[ch] : dec_w[ch];
         if (new_w[ch] < floor_w) begin
            new_w[ch] = floor_w;
         end
         if (new_w[ch] > 0) begin
            new_w[ch] = '0;
         end
         held_in[ch] = new_w[ch][spm_pkg::LEVEL_W-1:0];
      end
   end

   // bar thresholds and coarse quotient by 2048
   always_comb begin
      for (int ch = 0; ch < spm_pkg::NUM_CH; ch++) begin
         v_w[ch] = spm_pkg::V_W'(h_lvl_ff[ch]) * spm_pkg::BAR_SCALE + spm_pkg::BAR_OFFSET;
         b_zero_in[ch] = (v_w[ch] <= spm_pkg::BAR_LOW);
         b_full_in[ch] = (v_w[ch] > spm_pkg::BAR_HIGH);
         b_x_in[ch]    = v_w[ch][spm_pkg::BAR_SHIFT +: spm_pkg::X_W];
      end
   end

   // divide by five with a reciprocal, then saturate
   always_comb begin
      for (int ch = 0; ch < spm_pkg::NUM_CH; ch++) begin
         qp_w[ch] = spm_pkg::QP_W'(b_x_ff[ch]) * spm_pkg::RECIP_5;
         if (b_zero_ff[ch]) begin
            bar_w[ch] = spm_pkg::BAR_EMPTY;
         end else if (b_full_ff[ch]) begin
            bar_w[ch] = spm_pkg::BAR_FULL;
         end else begin
            bar_w[ch] = qp_w[ch][spm_pkg::RECIP_SHIFT +: spm_pkg::BAR_W];
         end
      end
   end

   // result beat
   always_comb begin
      rsp_data_in.chan0_level = b_lvl_ff[0];
      rsp_data_in.chan1_level = b_lvl_ff[1];
      rsp_data_in.chan0_bar   = bar_w[0];
      rsp_data_in.chan1_bar   = bar_w[1];
      rsp_data_in.over_range  = b_over_ff;
   end

   // control state and held levels
   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int ch = 0; ch < spm_pkg::NUM_CH; ch++) begin
            held_ff[ch] <= spm_pkg::FLOOR_RESET;
         end
      end else begin
         if (en_h_w) begin
            h_vld_ff <= q_valid;
         end
         if (en_b_w) begin
            b_vld_ff <= h_vld_ff;
         end
         if (en_o_w) begin
            rsp_valid_ff <= b_vld_ff;
         end
         if (q_pop) begin
            for (int ch = 0; ch < spm_pkg::NUM_CH; ch++) begin
               held_ff[ch] <= held_in[ch];
            end
         end
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (q_pop) begin
         h_over_ff <= q_data.over_range;
         for (int ch = 0; ch < spm_pkg::NUM_CH; ch++) begin
            h_lvl_ff[ch] <= held_in[ch];
         end
      end
      if (en_b_w) begin
         b_over_ff <= h_over_ff;
         b_zero_ff <= b_zero_in;
         b_full_ff <= b_full_in;
         for (int ch = 0; ch < spm_pkg::NUM_CH; ch++) begin
            b_lvl_ff[ch] <= h_lvl_ff[ch];
            b_x_ff[ch]   <= b_x_in[ch];
         end
      end
      if (en_o_w) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/stereo_peak_meter_db_decay_top.sv =====
`timescale 1ns / 1ps
// top level of the stereo peak meter with dBFS levels and linear fall-off
//
// Each input beat carries two channel peaks (or an idle tick); each result beat
// gives the new held level of both channels in 1/256 dB, a 0..100 bar height per
// channel and an over-range bit per channel. The block takes one beat every
// clock cycle while req_stall is low. The front end (input register, five-stage
// log2 unit per channel, two scaling stages) feeds a short queue, and the back
// end updates the held levels in a loop through the held-level registers before
// bar mapping and the result register. The user must write registers through
// the csr port only while no beat is in flight; the block does not enforce this.
module stereo_peak_meter_db_decay_top #(
   parameter int LOG_TABLE_ENTRIES = spm_pkg::LOG_TABLE_ENTRIES_DEF,
   parameter int PEAK_BITS         = spm_pkg::PEAK_BITS_DEF,
   parameter int QUEUE_DEPTH       = spm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  spm_pkg::spm_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output spm_pkg::spm_rsp_type            rsp_data,
   input  logic                            csr_wr_en,
   input  logic [spm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [spm_pkg::CSR_W-1:0]       csr_wdata
);

   spm_pkg::spm_cfg_type cfg_in, cfg_ff;
   logic                 q_full, q_push, q_valid, q_pop;
   spm_pkg::spm_pk_type  q_push_data, q_head;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (spm_pkg::spm_csr_index_type'(csr_index))
            spm_pkg::CSR_FULL_SCALE_SELECT: begin
               cfg_in.full_scale_select = csr_wdata[0];
            end
            spm_pkg::CSR_FALL_STEP: begin
               cfg_in.fall_step = csr_wdata[spm_pkg::FALL_W-1:0];
            end
            spm_pkg::CSR_FLOOR_LEVEL: begin
               cfg_in.floor_level = $signed(csr_wdata[spm_pkg::LEVEL_W-1:0]);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_scale_select <= spm_pkg::FS_SEL_RESET;
         cfg_ff.fall_step         <= spm_pkg::FALL_RESET;
         cfg_ff.floor_level       <= spm_pkg::FLOOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end
   spm_front #(
      .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES),
      .PEAK_BITS        (PEAK_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   // decoupling queue
   spm_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head_data (q_head)
   );

   // back end
   spm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_data   (q_head),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

// ===== bench/tb_stereo_peak_meter_db_decay_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the stereo peak meter top level
module tb_stereo_peak_meter_db_decay_top;
   import spm_pkg::*;

   localparam int     TAB_N         = 32;
   localparam int     CLK_HALF      = 4;
   localparam int     RESET_CYCLES  = 12;
   localparam int     SETTLE_CYCLES = 24;
   localparam int     CYCLE_LIMIT   = 200000;
   localparam int     BEATS_PER_CFG = 128;
   localparam longint DB_PER_OCTAVE = 394566;
   localparam int     BAR_STEP      = 10240;
   localparam int     BAR_TOP       = 1024000;
   localparam int     BAR_BIAS      = 1029120;
   localparam logic   MODE_PEAKS    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   spm_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   spm_rsp_type            rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]       csr_wdata = '0;

   // meter state mirrored by the predictor
   longint unsigned log2_frac_tab [0:TAB_N];
   int              held_dbq [2];
   logic            cfg_fs_sel;
   int              cfg_fall;
   int              cfg_floor;
   spm_rsp_type     pending_readings [$];

   int send_idle_pct    = 15;
   int stall_pct        = 66;
   int error_count      = 0;
   int beats_sent       = 0;
   int readings_checked = 0;
   int cycle_count      = 0;

   stereo_peak_meter_db_decay_top u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   always #(CLK_HALF) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d readings outstanding",
                  cycle_count, pending_readings.size());
         $display("stereo_peak_meter_db_decay_top verification failed");
         $finish;
      end
   end

   // random back-pressure on the result side
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   // table entry floor(65536*log2(1+i/n)) by repeated squaring
   function automatic longint unsigned log2_frac_entry(int i);
      longint unsigned x;
      longint unsigned acc;
      acc = 0;
      x   = (longint'(TAB_N + i) << 30) / TAB_N;
      if (i >= TAB_N) return 64'd65536;
      for (int b = 15; b >= 0; b--) begin
         x = (x * x) >> 30;
         if (x >= (64'd1 << 31)) begin
            x   = x >> 1;
            acc = acc | (64'd1 << b);
         end
      end
      return acc;
   endfunction

   // log2 in Q16: leading-one position plus interpolated fraction
   function automatic longint log2_q16(longint unsigned p);
      int              e;
      int              idx;
      longint unsigned f;
      longint unsigned prod;
      longint unsigned rem;
      longint unsigned lo;
      longint unsigned hi;
      e = 31;
      while (e > 0 && p[e] == 1'b0) e--;
      if (e >= 16) f = (p >> (e - 16)) & 64'hFFFF;
      else f = (p << (16 - e)) & 64'hFFFF;
      prod = f * TAB_N;
      idx  = int'(prod >> 16);
      rem  = prod & 64'hFFFF;
      if (idx >= TAB_N) idx = TAB_N - 1;
      lo = log2_frac_tab[idx];
      hi = log2_frac_tab[idx + 1];
      return (longint'(e) << 16) + longint'(lo) + longint'(((hi - lo) * rem) >> 16);
   endfunction

   // new held level of one channel; over flags a peak beyond full scale
   function automatic int chan_update(int held, longint unsigned p, longint unsigned fs,
                                      output logic over);
      longint d;
      longint prod;
      int     pk;
      int     dec;
      int     n;
      over = 1'b0;
      if (p == 0) begin
         pk = cfg_floor;
      end else if (p > fs) begin
         over = 1'b1;
         pk   = 0;
      end else begin
         d    = log2_q16(p) - log2_q16(fs);
         prod = d * DB_PER_OCTAVE + (longint'(1) << 23);
         pk   = int'(prod >>> 24);
         if (pk > 0) pk = 0;
      end
      dec = held - cfg_fall;
      n   = (pk > dec) ? pk : dec;
      if (n < cfg_floor) n = cfg_floor;
      if (n > 0) n = 0;
      return n;
   endfunction

   // bar over the 40 dB span
   function automatic logic [BAR_W-1:0] bar_height(int lvl);
      int v;
      v = 100 * lvl + BAR_BIAS;
      if (v <= BAR_STEP) return BAR_EMPTY;
      if (v > BAR_TOP) return BAR_FULL;
      return BAR_W'(v / BAR_STEP);
   endfunction

   // expected reading for one accepted beat, advancing the held levels
   function automatic spm_rsp_type meter_predict(spm_req_type beat);
      spm_rsp_type     r;
      longint unsigned fs;
      longint unsigned p0;
      longint unsigned p1;
      logic            o0;
      logic            o1;
      fs = cfg_fs_sel ? longint'(FS_32) : longint'(FS_16);
      if (beat.mode == MODE_IDLE) begin
         p0 = 1;
         p1 = 1;
      end else begin
         p0 = beat.chan0_peak;
         p1 = beat.chan1_peak;
      end
      held_dbq[0]   = chan_update(held_dbq[0], p0, fs, o0);
      held_dbq[1]   = chan_update(held_dbq[1], p1, fs, o1);
      r.chan0_level = LEVEL_W'(held_dbq[0]);
      r.chan1_level = LEVEL_W'(held_dbq[1]);
      r.chan0_bar   = bar_height(held_dbq[0]);
      r.chan1_bar   = bar_height(held_dbq[1]);
      r.over_range  = {o1, o0};
      return r;
   endfunction

   function automatic spm_req_type make_beat(logic mode, logic [PEAK_W-1:0] a,
                                             logic [PEAK_W-1:0] b);
      spm_req_type beat;
      beat.mode       = mode;
      beat.chan0_peak = a;
      beat.chan1_peak = b;
      return beat;
   endfunction

   // peak spread over the octaves, with zeros, raw words and values around full scale
   function automatic logic [PEAK_W-1:0] rand_peak(logic fs_sel);
      int kind;
      int e;
      kind = $urandom_range(0, 99);
      if (kind < 6) return '0;
      if (kind < 12) return PEAK_W'($urandom);
      if (kind < 18) begin
         if (fs_sel) return FS_32 - PEAK_W'($urandom_range(0, 7));
         return FS_16 + PEAK_W'($urandom_range(0, 8)) - PEAK_W'(4);
      end
      e = $urandom_range(0, fs_sel ? 30 : 16);
      return (PEAK_W'(1) << e) | (PEAK_W'($urandom) & ((PEAK_W'(1) << e) - PEAK_W'(1)));
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("ERROR cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
   endtask

   task automatic check_field(string what, longint got, longint want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // compare each reading beat with the oldest expectation
   always @(posedge clock) begin
      spm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("reading with none pending", 0, 0);
         end else begin
            want = pending_readings.pop_front();
            check_field("chan0_level", $signed(rsp_data.chan0_level),
                        $signed(want.chan0_level));
            check_field("chan1_level", $signed(rsp_data.chan1_level),
                        $signed(want.chan1_level));
            check_field("chan0_bar", rsp_data.chan0_bar, want.chan0_bar);
            check_field("chan1_bar", rsp_data.chan1_bar, want.chan1_bar);
            check_field("over_range", rsp_data.over_range, want.over_range);
            readings_checked++;
         end
      end
   end

   // predictor side of a register write
   function automatic void cfg_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_W-1:0] data);
      case (idx)
         CSR_FULL_SCALE_SELECT: cfg_fs_sel = data[0];
         CSR_FALL_STEP:         cfg_fall   = int'(data[FALL_W-1:0]);
         CSR_FLOOR_LEVEL:       cfg_floor  = int'($signed(data));
         default: ;
      endcase
   endfunction

   // leaves the write enable high; the caller lowers it after the last write
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      cfg_write(idx, data);
   endtask

   // unused upper bits of the narrow registers carry noise
   task automatic program_meter(logic fs_sel, int fall, int floor_dbq);
      write_csr(CSR_FULL_SCALE_SELECT, {15'($urandom), fs_sel});
      write_csr(CSR_FALL_STEP, {5'($urandom), FALL_W'(fall)});
      write_csr(CSR_FLOOR_LEVEL, CSR_W'(floor_dbq));
      csr_wr_en <= 1'b0;
   endtask

   // one input beat, with a random gap ahead of it
   task automatic send_beat(spm_req_type beat);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_readings.push_back(meter_predict(beat));
      beats_sent++;
   endtask

   // wait for every reading, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // reset state: idle tick first exposes the held level after reset
   task automatic test_reset_defaults();
      send_beat(make_beat(MODE_IDLE, '1, '1));
      send_beat(make_beat(MODE_PEAKS, '0, '0));
      send_beat(make_beat(MODE_PEAKS, FS_16, FS_16));
      send_beat(make_beat(MODE_PEAKS, FS_16 + PEAK_W'(1), '0));
      send_beat(make_beat(MODE_PEAKS, PEAK_W'(1), '1));
      settle();
   endtask

   task automatic test_wide_full_scale();
      program_meter(1'b1, 154, -10240);
      send_beat(make_beat(MODE_PEAKS, FS_32, FS_32));
      send_beat(make_beat(MODE_PEAKS, PEAK_W'(1), 31'h4000_0000));
      send_beat(make_beat(MODE_PEAKS, FS_16, 31'h0001_0000));
      send_beat(make_beat(MODE_PEAKS, '0, FS_32));
      settle();
   endtask

   // deepest floor with fastest fall, then shallowest floor with no fall
   task automatic test_floor_and_fall_extremes();
      program_meter(1'b1, 2047, -32768);
      send_beat(make_beat(MODE_PEAKS, PEAK_W'(1), PEAK_W'(1)));
      send_beat(make_beat(MODE_PEAKS, PEAK_W'(1), PEAK_W'(1)));
      send_beat(make_beat(MODE_PEAKS, FS_32, '0));
      send_beat(make_beat(MODE_PEAKS, '0, PEAK_W'(1)));
      settle();
      program_meter(1'b0, 0, -256);
      send_beat(make_beat(MODE_PEAKS, PEAK_W'(1), PEAK_W'(1)));
      send_beat(make_beat(MODE_PEAKS, '0, '0));
      settle();
   endtask

   // floor set above 0 dB still saturates at 0 dB
   task automatic test_floor_above_zero();
      program_meter(1'b0, 154, 512);
      send_beat(make_beat(MODE_PEAKS, '0, '0));
      send_beat(make_beat(MODE_IDLE, '0, '0));
      settle();
   endtask

   task automatic test_ignored_index();
      write_csr(CSR_UNUSED, '1);
      csr_wr_en <= 1'b0;
      send_beat(make_beat(MODE_PEAKS, FS_16 >> 1, PEAK_W'(3)));
      settle();
   endtask

   // bursts followed by quiet frames, mixed with unrelated beats
   task automatic test_random_traffic(int sender_pct, int receiver_pct, logic fs_first);
      int          blk;
      int          sent;
      int          run;
      int          kind;
      logic [PEAK_W-1:0] fs;
      send_idle_pct = sender_pct;
      stall_pct     = receiver_pct;
      for (blk = 0; blk < 3; blk++) begin
         settle();
         case (blk)
            0: program_meter(fs_first, 2047, -32768);
            1: program_meter(!fs_first, 0, -int'($urandom_range(256, 32768)));
            default: program_meter($urandom_range(0, 1), $urandom_range(0, 2047),
                                   -int'($urandom_range(256, 32768)));
         endcase
         sent = 0;
         while (sent < BEATS_PER_CFG) begin
            fs = cfg_fs_sel ? FS_32 : FS_16;
            if ($urandom_range(0, 99) < 70) begin
               // loud frame, then a fall-off run
               send_beat(make_beat(MODE_PEAKS,
                                   (fs >> $urandom_range(0, 6)) - PEAK_W'($urandom_range(0, 255)),
                                   (fs >> $urandom_range(0, 6)) - PEAK_W'($urandom_range(0, 255))));
               sent++;
               run = $urandom_range(3, 12);
               repeat (run) begin
                  kind = $urandom_range(0, 3);
                  if (kind < 2)
                     send_beat(make_beat(MODE_IDLE, PEAK_W'($urandom), PEAK_W'($urandom)));
                  else
                     send_beat(make_beat(MODE_PEAKS, PEAK_W'($urandom_range(0, 255)),
                                         PEAK_W'($urandom_range(0, 255))));
                  sent++;
               end
            end else begin
               send_beat(make_beat(($urandom_range(0, 9) == 0) ? MODE_IDLE : MODE_PEAKS,
                                   rand_peak(cfg_fs_sel), rand_peak(cfg_fs_sel)));
               sent++;
            end
         end
      end
   endtask

   initial begin
      for (int i = 0; i <= TAB_N; i++) log2_frac_tab[i] = log2_frac_entry(i);
      cfg_fs_sel  = FS_SEL_RESET;
      cfg_fall    = int'(FALL_RESET);
      cfg_floor   = int'(FLOOR_RESET);
      held_dbq[0] = int'(FLOOR_RESET);
      held_dbq[1] = int'(FLOOR_RESET);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_wide_full_scale();
      test_floor_and_fall_extremes();
      test_floor_above_zero();
      test_ignored_index();
      test_random_traffic(15, 66, 1'b0);
      test_random_traffic(66, 15, 1'b1);
      test_random_traffic(0, 0, 1'b0);
      settle();

      if (pending_readings.size() != 0)
         report_mismatch("readings never delivered", 0, pending_readings.size());
      $display("%0d beats sent, %0d readings checked, %0d mismatches",
               beats_sent, readings_checked, error_count);
      $display("both full scales, fall 0..2047, floors -128 dB to above 0 dB, idle ticks,",
               " over-range peaks and three sender/receiver stall mixes");
      if (error_count == 0) begin
         $display("stereo_peak_meter_db_decay_top verification clean");
      end else begin
         $display("stereo_peak_meter_db_decay_top verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/spm_pkg.sv
sv/spm_log2.sv
sv/spm_front.sv
sv/spm_queue.sv
sv/spm_back.sv
sv/stereo_peak_meter_db_decay_top.sv
bench/tb_stereo_peak_meter_db_decay_top.sv
